/* rtl/delta_dual_moving_average_core_defines.svh */
`ifndef DELTA_DUAL_MOVING_AVERAGE_CORE_DEFINES_SVH
`define DELTA_DUAL_MOVING_AVERAGE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DDMA_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define DDMA_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ddma_pkg.sv */
`default_nettype none

package ddma_pkg;

    // default sizes of history and ring
    localparam int HISTORY_LIMIT_DEF = 1024;
    localparam int MAX_WINDOW_DEF    = 16;

    // field widths
    localparam int READING_W = 32;
    localparam int DELTA_W   = 33;
    localparam int HIGH_W    = 32;
    localparam int AVG_W     = 41;
    localparam int INDEX_W   = 32;
    localparam int WIN_W     = 5;
    localparam int FRAC_W    = 8;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_FIELD_W = DELTA_W + DELTA_W + HIGH_W + AVG_W + 1 + AVG_W + 1 + INDEX_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // reset values
    localparam logic [DELTA_W-1:0] LOW_MARK_RESET     = DELTA_W'(999999999);
    localparam logic [WIN_W-1:0]   SHORT_WINDOW_RESET = WIN_W'(10);
    localparam logic [WIN_W-1:0]   LONG_WINDOW_RESET  = WIN_W'(15);

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT_WINDOW = 1'b0,
        CFG_LONG_WINDOW  = 1'b1
    } t_cfg_index;

endpackage

`default_nettype wire

/* rtl/delta_dual_moving_average_core.sv */
// operation: an accepted reading goes through a sweep of the delta ring, newest entry first,
// at one read a cycle, then a prep step, then the two serial dividers at two quotient bits
// a cycle (DIV_STEPS = 22 at the default ring depth); a new reading is accepted only after
// the previous result has been loaded into the output register
// reset: synchronous, active low; clears control state and restores windows to 10 and 15,
// the delta ring is not cleared since an entry is only averaged after it has been written
`default_nettype none
`include "delta_dual_moving_average_core_defines.svh"

module delta_dual_moving_average_core #(
    parameter int HISTORY_LIMIT = ddma_pkg::HISTORY_LIMIT_DEF,
    parameter int MAX_WINDOW    = ddma_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // reading[31:0]
    input  wire logic [ddma_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // result stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // delta[32:0], low_mark[65:33], high_mark[97:66], short_average[138:98],
    // short_valid[139], long_average[180:140], long_valid[181], sample_index[213:182]
    output logic [ddma_pkg::OUT_TDATA_W-1:0]         o_m_tdata,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [ddma_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  wire logic [ddma_pkg::WIN_W-1:0]          i_cfg_wdata
);

    import ddma_pkg::*;

    localparam int PTR_W     = $clog2(MAX_WINDOW);
    localparam int PC_W      = $clog2(HISTORY_LIMIT + 1);
    localparam int CMP_W     = (PC_W > WIN_W + 1) ? PC_W : WIN_W + 1;
    localparam int WIN_CAP   = (MAX_WINDOW < (1 << WIN_W) - 1) ? MAX_WINDOW : (1 << WIN_W) - 1;
    localparam int SUM_W     = DELTA_W + $clog2(MAX_WINDOW);
    localparam int MAG_W     = SUM_W - 1;
    localparam int DIV_BITS  = MAG_W + FRAC_W;
    localparam int DIV_STEPS = (DIV_BITS + 1) / 2;
    localparam int DIVD_W    = 2 * DIV_STEPS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_PREP,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    // two restoring division steps on the narrow remainder, quotient shifts into num
    function automatic logic [WIN_W+DIVD_W-1:0] div_two_bits(
        input logic [DIVD_W-1:0] num,
        input logic [WIN_W-1:0]  rem,
        input logic [WIN_W-1:0]  dvs
    );
        logic [DIVD_W-1:0] n;
        logic [WIN_W-1:0]  r;
        logic [WIN_W:0]    t;
        n = num;
        r = rem;
        for (int i = 0; i < 2; i++) begin
            t = {r, n[DIVD_W-1]};
            n = {n[DIVD_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                r    = WIN_W'(t - {1'b0, dvs});
                n[0] = 1'b1;
            end else begin
                r = t[WIN_W-1:0];
            end
        end
        return {r, n};
    endfunction

    t_state r_state;

    // configuration
    logic [WIN_W-1:0] r_short_window;
    logic [WIN_W-1:0] r_long_window;

    // running state
    logic                       r_first_pending;
    logic [READING_W-1:0]       r_prev_reading;
    logic signed [DELTA_W-1:0]  r_low;
    logic [HIGH_W-1:0]          r_high;
    logic [PTR_W-1:0]           r_ring_ptr;
    logic [PC_W-1:0]            r_point_count;
    logic [INDEX_W-1:0]         r_tick;

    // delta ring memory
    logic signed [DELTA_W-1:0]  ring_mem [MAX_WINDOW];
    logic signed [DELTA_W-1:0]  r_rd_data;

    // per-item working registers
    logic [WIN_W-1:0]           r_sw;
    logic [WIN_W-1:0]           r_lw;
    logic [WIN_W-1:0]           r_wmax;
    logic                       r_s_vld;
    logic                       r_l_vld;
    logic signed [DELTA_W-1:0]  r_res_delta;
    logic signed [DELTA_W-1:0]  r_res_low;
    logic [HIGH_W-1:0]          r_res_high;
    logic [INDEX_W-1:0]         r_res_index;
    logic [PTR_W-1:0]           r_rd_addr;
    logic [WIN_W-1:0]           r_issued;
    logic [WIN_W-1:0]           r_taken;
    logic                       r_rd_vld;
    logic signed [SUM_W-1:0]    r_acc;
    logic signed [SUM_W-1:0]    r_s_sum;
    logic signed [SUM_W-1:0]    r_l_sum;
    logic                       r_s_neg;
    logic                       r_l_neg;
    logic [DIVD_W-1:0]          r_s_num;
    logic [DIVD_W-1:0]          r_l_num;
    logic [WIN_W-1:0]           r_s_rem;
    logic [WIN_W-1:0]           r_l_rem;
    logic [STEP_W-1:0]          r_step;

    // output register
    logic                       r_out_vld;
    logic [OUT_TDATA_W-1:0]     r_out_data;

    logic                       w_accept;
    logic                       w_mem_we;
    logic                       w_mem_re;
    logic [READING_W-1:0]       w_reading;
    logic signed [DELTA_W-1:0]  w_delta;
    logic signed [DELTA_W-1:0]  w_high_ext;
    logic signed [DELTA_W-1:0]  w_low_next;
    logic [HIGH_W-1:0]          w_high_next;
    logic [PTR_W-1:0]           w_ptr_next;
    logic [PC_W-1:0]            w_pc_next;
    logic [WIN_W-1:0]           w_sw;
    logic [WIN_W-1:0]           w_lw;
    logic [PTR_W-1:0]           w_rd_addr;
    logic signed [SUM_W-1:0]    w_acc_next;
    logic [WIN_W-1:0]           w_taken_next;
    logic [MAG_W-1:0]           w_s_mag;
    logic [MAG_W-1:0]           w_l_mag;
    logic [AVG_W-1:0]           w_s_q;
    logic [AVG_W-1:0]           w_l_q;
    logic [AVG_W-1:0]           w_s_avg;
    logic [AVG_W-1:0]           w_l_avg;
    logic                       w_out_load;

    // handshake
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign w_out_load = (r_state == ST_DONE) && (!r_out_vld || i_m_tready);

    // difference and running marks
    assign w_reading  = i_s_tdata[READING_W-1:0];
    assign w_delta    = r_first_pending ? '0
                      : $signed({1'b0, w_reading} - {1'b0, r_prev_reading});
    assign w_high_ext = $signed({1'b0, r_high});
    assign w_low_next = (w_delta < r_low) ? w_delta : r_low;
    assign w_high_next = (w_delta > w_high_ext) ? w_delta[HIGH_W-1:0] : r_high;

    // ring pointer and point count
    assign w_ptr_next = (r_ring_ptr == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_ring_ptr + PTR_W'(1);
    assign w_pc_next  = (r_point_count == PC_W'(HISTORY_LIMIT)) ? r_point_count
                      : r_point_count + PC_W'(1);

    // window clamping
    assign w_sw = (r_short_window == '0) ? WIN_W'(1)
                : (r_short_window > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : r_short_window;
    assign w_lw = (r_long_window == '0) ? WIN_W'(1)
                : (r_long_window > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : r_long_window;

    // sweep backwards through the ring, newest entry first
    assign w_mem_we     = w_accept;
    assign w_mem_re     = (r_state == ST_SWEEP) && (r_issued != r_wmax);
    assign w_rd_addr    = (r_rd_addr == '0) ? PTR_W'(MAX_WINDOW - 1) : r_rd_addr - PTR_W'(1);
    assign w_acc_next   = r_acc + SUM_W'(r_rd_data);
    assign w_taken_next = r_taken + WIN_W'(1);

    // magnitudes for the dividers
    assign w_s_mag = r_s_sum[SUM_W-1] ? MAG_W'(-r_s_sum) : MAG_W'(r_s_sum);
    assign w_l_mag = r_l_sum[SUM_W-1] ? MAG_W'(-r_l_sum) : MAG_W'(r_l_sum);

    // signed averages from the quotients
    assign w_s_q   = r_s_num[AVG_W-1:0];
    assign w_l_q   = r_l_num[AVG_W-1:0];
    assign w_s_avg = !r_s_vld ? '0 : (r_s_neg ? -w_s_q : w_s_q);
    assign w_l_avg = !r_l_vld ? '0 : (r_l_neg ? -w_l_q : w_l_q);

    // ring memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            ring_mem[r_ring_ptr] <= w_delta;
        end
        if (w_mem_re) begin
            r_rd_data <= ring_mem[w_rd_addr];
        end
    end

    // sequencer, running state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_short_window  <= SHORT_WINDOW_RESET;
            r_long_window   <= LONG_WINDOW_RESET;
            r_first_pending <= 1'b1;
            r_prev_reading  <= '0;
            r_low           <= LOW_MARK_RESET;
            r_high          <= '0;
            r_ring_ptr      <= '0;
            r_point_count   <= '0;
            r_tick          <= '0;
            r_rd_vld        <= 1'b0;
            r_out_vld       <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_addr))
                    CFG_SHORT_WINDOW: r_short_window <= i_cfg_wdata;
                    CFG_LONG_WINDOW:  r_long_window  <= i_cfg_wdata;
                endcase
            end

            // result register drains independently of the sequencer
            if (w_out_load) begin
                r_out_vld  <= 1'b1;
                r_out_data <= OUT_TDATA_W'({r_res_index, r_l_vld, w_l_avg, r_s_vld, w_s_avg,
                                            r_res_high, r_res_low, r_res_delta});
            end else if (r_out_vld && i_m_tready) begin
                r_out_vld <= 1'b0;
            end

            r_rd_vld <= w_mem_re;

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_first_pending <= 1'b0;
                        r_prev_reading  <= w_reading;
                        r_low           <= w_low_next;
                        r_high          <= w_high_next;
                        r_ring_ptr      <= w_ptr_next;
                        r_point_count   <= w_pc_next;
                        r_tick          <= r_tick + INDEX_W'(1);
                        r_res_delta     <= w_delta;
                        r_res_low       <= w_low_next;
                        r_res_high      <= w_high_next;
                        r_res_index     <= r_tick;
                        r_sw            <= w_sw;
                        r_lw            <= w_lw;
                        r_wmax          <= (w_sw > w_lw) ? w_sw : w_lw;
                        r_s_vld         <= CMP_W'(w_pc_next) > CMP_W'(w_sw) + CMP_W'(1);
                        r_l_vld         <= CMP_W'(w_pc_next) > CMP_W'(w_lw) + CMP_W'(1);
                        r_rd_addr       <= w_ptr_next;
                        r_issued        <= '0;
                        r_taken         <= '0;
                        r_acc           <= '0;
                        r_state         <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (w_mem_re) begin
                        r_rd_addr <= w_rd_addr;
                        r_issued  <= r_issued + WIN_W'(1);
                    end
                    if (r_rd_vld) begin
                        r_acc   <= w_acc_next;
                        r_taken <= w_taken_next;
                        if (w_taken_next == r_sw) begin
                            r_s_sum <= w_acc_next;
                        end
                        if (w_taken_next == r_lw) begin
                            r_l_sum <= w_acc_next;
                        end
                        if (w_taken_next == r_wmax) begin
                            r_state <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    r_s_neg <= r_s_sum[SUM_W-1];
                    r_l_neg <= r_l_sum[SUM_W-1];
                    r_s_num <= DIVD_W'({w_s_mag, FRAC_W'(0)});
                    r_l_num <= DIVD_W'({w_l_mag, FRAC_W'(0)});
                    r_s_rem <= '0;
                    r_l_rem <= '0;
                    r_step  <= STEP_W'(DIV_STEPS - 1);
                    r_state <= ST_DIVIDE;
                end
                ST_DIVIDE: begin
                    {r_s_rem, r_s_num} <= div_two_bits(r_s_num, r_s_rem, r_sw);
                    {r_l_rem, r_l_num} <= div_two_bits(r_l_num, r_l_rem, r_lw);
                    if (r_step == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_step <= r_step - STEP_W'(1);
                    end
                end
                ST_DONE: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // checks
    `DDMA_CHECK(a_mark_order, !r_first_pending, r_low <= w_high_ext, "low mark above high mark")
    `DDMA_CHECK_NEXT(a_result_loaded, w_out_load, o_m_tvalid && o_s_tready, "result not loaded")
    `DDMA_CHECK_NEXT(a_busy_after_accept, w_accept, !o_s_tready && !w_mem_we, "accepted while busy")
    `DDMA_CHECK(a_window_bounds, r_state != ST_IDLE,
        r_sw != '0 && r_lw != '0 && r_wmax >= r_sw && r_wmax >= r_lw, "bad window latch")

endmodule

`default_nettype wire
